@@ sv/markup_tag_keyword_classifier_defines.svh @@
// Assertion macros for the markup tag keyword classifier.
`ifndef MARKUP_TAG_KEYWORD_CLASSIFIER_DEFINES_SVH
`define MARKUP_TAG_KEYWORD_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
`define MTKC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MTKC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define MTKC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTKC_ASSERT(lbl, prop, msg)
`define MTKC_ASSERT_IMPL(lbl, ante, cons, msg)
`define MTKC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/mtkc_pkg.sv @@
// Types, character codes and keyword table for the markup tag classifier.
package mtkc_pkg;

  localparam int unsigned KwTable    = 25;
  localparam int unsigned KwCodeW    = 5;
  localparam int unsigned NameOffW   = 5;
  localparam logic [NameOffW-1:0] NameOffMax = 5'd31;

  localparam logic [7:0] ChLt     = 8'h3C;  // '<'
  localparam logic [7:0] ChGt     = 8'h3E;  // '>'
  localparam logic [7:0] ChNl     = 8'h0A;  // newline
  localparam logic [7:0] ChSlash  = 8'h2F;  // '/'
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] CaseFold = 8'd32;

  typedef enum logic [1:0] {
    ChunkText  = 2'd0,
    ChunkUnrec = 2'd1,
    ChunkRec   = 2'd2,
    ChunkEnd   = 2'd3
  } chunk_kind_e;

  typedef struct packed {
    chunk_kind_e         chunk_kind;
    logic [KwCodeW-1:0]  keyword_code;
    logic                closing_tag;
    logic                last_of_run;
  } res_t;

  // Keywords, right justified: the last character sits in the low byte.
  localparam logic [127:0] KwStr [KwTable] = '{
    128'("A"), 128'("B"), 128'("BODY"), 128'("FONT"), 128'("H1"), 128'("H2"),
    128'("H3"), 128'("H4"), 128'("H5"), 128'("H6"), 128'("HEAD"), 128'("HR"),
    128'("HREF"), 128'("HTML"), 128'("IMG"), 128'("META"), 128'("NAME"),
    128'("P"), 128'("SRC"), 128'("!STARTCMT"), 128'("!ENDCMT"), 128'("U"),
    128'("VAR"), 128'("/"), 128'("=")
  };

  localparam logic [3:0] KwLen [KwTable] = '{
    4'd1, 4'd1, 4'd4, 4'd4, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
    4'd4, 4'd2, 4'd4, 4'd4, 4'd3, 4'd4, 4'd4, 4'd1, 4'd3,
    4'd9, 4'd7, 4'd1, 4'd3, 4'd1, 4'd1
  };

  // Character at position pos of keyword idx; zero past its end.
  function automatic logic [7:0] kw_char(input int unsigned idx,
                                         input logic [NameOffW-1:0] pos);
    logic [3:0] sh;
    logic [7:0] ch;
    sh = '0;
    ch = ChNul;
    if (pos < {1'b0, KwLen[idx]}) begin
      sh = KwLen[idx] - 4'd1 - pos[3:0];
      ch = KwStr[idx][{sh, 3'b000} +: 8];
    end
    return ch;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic logic is_anum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

@@ sv/mtkc_if.sv @@
// Valid/ready channel interfaces for stream bytes and classified chunks.
interface mtkc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface mtkc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] chunk_kind;
  logic [4:0] keyword_code;
  logic       closing_tag;
  logic       last_of_run;

  modport source (output valid, output chunk_kind, output keyword_code,
                  output closing_tag, output last_of_run, input ready);
  modport sink   (input valid, input chunk_kind, input keyword_code,
                  input closing_tag, input last_of_run, output ready);
endinterface

@@ sv/markup_tag_keyword_classifier.sv @@
// Markup tag keyword classifier: byte stream in, classified chunks out.
//
// Takes one markup byte per request and cuts the stream into text runs
// (ending before '<' or after a newline) and tags ('<' through '>'). Tag
// names are folded to upper case and matched against all keywords at once,
// within the first TAG_WINDOW bytes after '<'; the lowest table position
// that matches gives keyword_code. A byte request with end_of_input set
// flushes the open chunk and adds an end marker. Throughput is one byte
// request per cycle: each byte updates the chunk and name-matching state,
// and its results are registered in a four-entry output queue that drives
// the output channel. Input is taken while the queue has two free entries;
// an end-of-input request that flushes a chunk yields two results and so
// takes two queue entries. The output sink may stall freely; no result is
// lost or repeated.
`include "markup_tag_keyword_classifier_defines.svh"

module markup_tag_keyword_classifier
  import mtkc_pkg::*;
#(
  parameter int unsigned TAG_WINDOW    = 28,
  parameter int unsigned KEYWORD_COUNT = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mtkc_in_if.sink           in_i,
  mtkc_out_if.source        out_o
);

  localparam int unsigned KwUsed = (KEYWORD_COUNT < KwTable) ? KEYWORD_COUNT : KwTable;
  localparam int unsigned UsedW  = $clog2(TAG_WINDOW + 1);
  localparam logic [UsedW-1:0] Win = UsedW'(TAG_WINDOW);
  localparam int unsigned Depth  = 4;
  localparam int unsigned PtrW   = 2;
  localparam int unsigned CntW   = 3;

  typedef enum logic [1:0] {ModeIdle, ModeText, ModeTag} mode_e;
  typedef enum logic [1:0] {PhLead, PhAfterSlash, PhName, PhClosed} phase_e;

  // Chunk and name-matching state
  mode_e               mode_q, mode_d;
  phase_e              ph_q, ph_d;
  logic [NameOffW-1:0] off_q, off_d;
  logic [UsedW-1:0]    used_q, used_d;
  logic [KwUsed-1:0]   alive_q, alive_d;
  logic [KwCodeW-1:0]  code_q, code_d;
  logic                found_q, found_d;
  logic                slash_q, slash_d;

  // Result queue
  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic        acc, pop, eoi;
  logic [7:0]  b, c_up;

  // Window step
  phase_e              w_ph;
  logic [NameOffW-1:0] w_off;
  logic [UsedW-1:0]    w_used;
  logic [KwUsed-1:0]   w_alive, rec_a;
  logic                w_slash, fin_w, name_go;

  // Tag finish
  logic                step;
  phase_e              t_ph;
  logic [NameOffW-1:0] t_off;
  logic [UsedW-1:0]    t_used;
  logic [KwUsed-1:0]   t_alive, rec_all;
  logic                t_slash, fin, emit_tag;
  logic [KwCodeW-1:0]  m_code, f_code;
  logic                f_found;

  res_t        res0, res1, tag_res;
  logic [1:0]  push_n;

  assign eoi = in_i.end_of_input;
  assign b   = in_i.data_byte;
  assign in_i.ready = (cnt_q <= CntW'(Depth - 2));
  assign acc = in_i.valid && in_i.ready;

  assign out_o.valid        = (cnt_q != '0);
  assign out_o.chunk_kind   = mem_q[rd_q].chunk_kind;
  assign out_o.keyword_code = mem_q[rd_q].keyword_code;
  assign out_o.closing_tag  = mem_q[rd_q].closing_tag;
  assign out_o.last_of_run  = mem_q[rd_q].last_of_run;
  assign pop = out_o.valid && out_o.ready;

  // One byte through the name window
  always_comb begin
    c_up    = (b >= 8'h61 && b <= 8'h7A) ? (b - CaseFold) : b;
    w_ph    = ph_q;
    w_off   = off_q;
    w_used  = used_q;
    w_alive = alive_q;
    w_slash = slash_q;
    rec_a   = '0;
    fin_w   = 1'b0;
    name_go = 1'b0;
    if (ph_q != PhClosed) begin
      if (b == ChNul || used_q >= Win) begin
        fin_w = 1'b1;
      end else begin
        w_used = used_q + 1'b1;
        case (ph_q)
          PhLead: begin
            if (is_blank(b)) begin
              w_ph = PhLead;
            end else if (b == ChSlash) begin
              w_slash = 1'b1;
              w_ph    = PhAfterSlash;
            end else begin
              w_ph    = PhName;
              name_go = 1'b1;
            end
          end
          PhAfterSlash: begin
            if (!is_blank(b)) begin
              w_ph    = PhName;
              name_go = 1'b1;
            end
          end
          default: name_go = 1'b1;
        endcase
        if (w_used >= Win) fin_w = 1'b1;
      end
    end
    if (name_go) begin
      for (int unsigned i = 0; i < KwUsed; i++) begin
        rec_a[i]   = alive_q[i] && ({1'b0, KwLen[i]} == off_q) && !is_anum(c_up);
        w_alive[i] = alive_q[i] && (off_q < {1'b0, KwLen[i]}) && (kw_char(i, off_q) == c_up);
      end
      w_off = (off_q == NameOffMax) ? off_q : off_q + 1'b1;
    end
  end

  // Close the name window where needed and pick the lowest match
  always_comb begin
    step     = (mode_q == ModeTag) && !eoi;
    emit_tag = (mode_q == ModeTag) && (eoi || b == ChGt);
    t_ph     = step ? w_ph : ph_q;
    t_off    = step ? w_off : off_q;
    t_used   = step ? w_used : used_q;
    t_alive  = step ? w_alive : alive_q;
    t_slash  = step ? w_slash : slash_q;
    fin      = (step && fin_w) || emit_tag;
    rec_all  = step ? rec_a : '0;
    if (fin && t_ph == PhName) begin
      for (int unsigned i = 0; i < KwUsed; i++) begin
        if (t_alive[i] && ({1'b0, KwLen[i]} == t_off)) rec_all[i] = 1'b1;
      end
    end
    m_code = '0;
    for (int i = int'(KwUsed) - 1; i >= 0; i--) begin
      if (rec_all[i]) m_code = KwCodeW'(i);
    end
    f_code  = code_q;
    f_found = found_q;
    if (rec_all != '0 && (!found_q || m_code < code_q)) begin
      f_code  = m_code;
      f_found = 1'b1;
    end
    tag_res.chunk_kind   = f_found ? ChunkRec : ChunkUnrec;
    tag_res.keyword_code = f_found ? f_code : '0;
    tag_res.closing_tag  = t_slash;
    tag_res.last_of_run  = 1'b1;
  end

  // Chunk control and result selection
  always_comb begin
    mode_d  = mode_q;
    ph_d    = ph_q;
    off_d   = off_q;
    used_d  = used_q;
    alive_d = alive_q;
    code_d  = code_q;
    found_d = found_q;
    slash_d = slash_q;
    res0    = '{chunk_kind: ChunkText, keyword_code: '0, closing_tag: 1'b0,
                last_of_run: 1'b1};
    res1    = '{chunk_kind: ChunkEnd, keyword_code: '0, closing_tag: 1'b0,
                last_of_run: 1'b1};
    push_n  = 2'd0;
    if (acc) begin
      if (eoi) begin
        case (mode_q)
          ModeText: begin
            res0.last_of_run = 1'b0;
            push_n = 2'd2;
          end
          ModeTag: begin
            res0 = tag_res;
            res0.last_of_run = 1'b0;
            push_n = 2'd2;
          end
          default: begin
            res0   = res1;
            push_n = 2'd1;
          end
        endcase
        mode_d = ModeIdle;
      end else begin
        case (mode_q)
          ModeIdle: mode_d = (b == ChLt) ? ModeTag : ModeText;
          ModeText: begin
            if (b == ChLt) begin
              push_n = 2'd1;
              mode_d = ModeTag;
            end else if (b == ChNl) begin
              push_n = 2'd1;
              mode_d = ModeIdle;
            end
          end
          ModeTag: begin
            ph_d    = fin ? PhClosed : t_ph;
            off_d   = t_off;
            used_d  = t_used;
            alive_d = t_alive;
            code_d  = f_code;
            found_d = f_found;
            slash_d = t_slash;
            if (b == ChGt) begin
              res0   = tag_res;
              push_n = 2'd1;
              mode_d = ModeIdle;
            end
          end
          default: mode_d = ModeIdle;
        endcase
      end
      // new tag or new stream: fresh name state
      if (eoi || (b == ChLt && mode_q != ModeTag)) begin
        ph_d    = PhLead;
        off_d   = '0;
        used_d  = '0;
        alive_d = '1;
        code_d  = '0;
        found_d = 1'b0;
        slash_d = 1'b0;
      end
    end
    wr_d  = wr_q + PtrW'(push_n);
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + CntW'(push_n) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      ph_q    <= PhLead;
      off_q   <= '0;
      used_q  <= '0;
      alive_q <= '1;
      code_q  <= '0;
      found_q <= 1'b0;
      slash_q <= 1'b0;
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      ph_q    <= ph_d;
      off_q   <= off_d;
      used_q  <= used_d;
      alive_q <= alive_d;
      code_q  <= code_d;
      found_q <= found_d;
      slash_q <= slash_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      cnt_q   <= cnt_d;
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) mem_q[wr_q] <= res0;
    if (push_n == 2'd2) mem_q[wr_q + 1'b1] <= res1;
  end

  `MTKC_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "result queue overflow")
  `MTKC_ASSERT(a_window_bound, used_q <= Win, "name window count past its end")
  `MTKC_ASSERT_NEXT(a_eoi_idle, acc && eoi, mode_q == ModeIdle && used_q == '0,
                    "end of input did not return to idle")
  `MTKC_ASSERT_IMPL(a_found_code, found_q, code_q < KwCodeW'(KwUsed),
                    "found keyword code outside the table")
  `MTKC_ASSERT_IMPL(a_code_zero, out_o.valid && out_o.chunk_kind != ChunkRec,
                    out_o.keyword_code == '0, "keyword code set on a non-keyword result")

endmodule

@@ test/mtkc_chunk_checker.sv @@
// Chunk checker: predicts classified chunks from accepted bytes and compares.
`timescale 1ns / 100ps

module mtkc_chunk_checker
  import mtkc_pkg::*;
#(
  parameter int unsigned TAG_WINDOW = 28
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mtkc_in_if                 in_ch,
  mtkc_out_if                out_ch,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        text_cnt_o,
  output int unsigned        tag_cnt_o,
  output int unsigned        end_cnt_o,
  output logic [KwTable-1:0] kw_seen_o
);

  typedef enum logic [1:0] {StIdle, StText, StTag} chunk_state_e;
  typedef enum logic [1:0] {PhLead, PhAfterSlash, PhName, PhClosed} name_phase_e;

  // Keyword table, in code order.
  string kw_word [KwTable] = '{
    "A", "B", "BODY", "FONT", "H1", "H2", "H3", "H4", "H5", "H6",
    "HEAD", "HR", "HREF", "HTML", "IMG", "META", "NAME", "P", "SRC",
    "!STARTCMT", "!ENDCMT", "U", "VAR", "/", "="
  };

  chunk_state_e        chunk_st;
  name_phase_e         phase;
  int unsigned         name_len;
  int unsigned         win_used;
  logic [KwTable-1:0]  alive;
  logic [KwCodeW-1:0]  hit_code;
  logic                hit;
  logic                slash;

  res_t                chunk_q [$];
  res_t                step_res [2];
  int unsigned         step_n;
  int unsigned         fails;
  int unsigned         n_text, n_tag, n_end;
  logic [KwTable-1:0]  kw_seen;

  function automatic logic word_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    return c == ChSpace || c == ChTab;
  endfunction

  task automatic open_name();
    phase    = PhLead;
    name_len = 0;
    win_used = 0;
    alive    = '1;
    hit_code = '0;
    hit      = 1'b0;
    slash    = 1'b0;
  endtask

  task automatic note_hit(input int unsigned i);
    if (!hit || i < hit_code) begin
      hit_code = KwCodeW'(i);
      hit      = 1'b1;
    end
  endtask

  task automatic close_name();
    if (phase == PhName)
      for (int unsigned i = 0; i < KwTable; i++)
        if (alive[i] && kw_word[i].len() == name_len) note_hit(i);
    phase = PhClosed;
  endtask

  task automatic take_name_char(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - CaseFold : c;
    for (int unsigned i = 0; i < KwTable; i++) begin
      if (alive[i]) begin
        if (kw_word[i].len() == name_len && !word_char(u)) note_hit(i);
        if (!(name_len < kw_word[i].len() && kw_word[i][name_len] == u)) alive[i] = 1'b0;
      end
    end
    if (name_len < 31) name_len++;
  endtask

  task automatic window_step(input logic [7:0] b);
    if (phase == PhClosed) return;
    if (b == ChNul || win_used >= TAG_WINDOW) begin
      close_name();
      return;
    end
    win_used++;
    case (phase)
      PhLead: begin
        if (blank_char(b)) begin
        end else if (b == ChSlash) begin
          slash = 1'b1;
          phase = PhAfterSlash;
        end else begin
          phase = PhName;
          take_name_char(b);
        end
      end
      PhAfterSlash: begin
        if (!blank_char(b)) begin
          phase = PhName;
          take_name_char(b);
        end
      end
      default: take_name_char(b);
    endcase
    if (win_used >= TAG_WINDOW) close_name();
  endtask

  task automatic emit(input chunk_kind_e kind, input logic [KwCodeW-1:0] code,
                      input logic closing);
    step_res[step_n] = '{chunk_kind: kind, keyword_code: code, closing_tag: closing,
                         last_of_run: 1'b0};
    step_n++;
  endtask

  task automatic emit_tag();
    close_name();
    if (hit) emit(ChunkRec, hit_code, slash);
    else     emit(ChunkUnrec, '0, slash);
  endtask

  task automatic predict_request(input logic [7:0] b, input logic eoi);
    step_n = 0;
    if (eoi) begin
      if (chunk_st == StText)     emit(ChunkText, '0, 1'b0);
      else if (chunk_st == StTag) emit_tag();
      emit(ChunkEnd, '0, 1'b0);
      chunk_st = StIdle;
      open_name();
    end else begin
      case (chunk_st)
        StIdle: begin
          if (b == ChLt) begin
            open_name();
            chunk_st = StTag;
          end else begin
            chunk_st = StText;
          end
        end
        StText: begin
          if (b == ChLt) begin
            emit(ChunkText, '0, 1'b0);
            open_name();
            chunk_st = StTag;
          end else if (b == ChNl) begin
            emit(ChunkText, '0, 1'b0);
            chunk_st = StIdle;
          end
        end
        default: begin
          window_step(b);
          if (b == ChGt) begin
            emit_tag();
            chunk_st = StIdle;
          end
        end
      endcase
    end
    if (step_n > 0) step_res[step_n-1].last_of_run = 1'b1;
    for (int unsigned i = 0; i < step_n; i++) chunk_q.push_back(step_res[i]);
  endtask

  task automatic flag(input string msg);
    fails++;
    if (fails <= 10) $display("[%0t] %s", $time, msg);
  endtask

  task automatic check_chunk();
    res_t want;
    res_t got;
    got.chunk_kind   = chunk_kind_e'(out_ch.chunk_kind);
    got.keyword_code = out_ch.keyword_code;
    got.closing_tag  = out_ch.closing_tag;
    got.last_of_run  = out_ch.last_of_run;
    if (chunk_q.size() == 0) begin
      flag($sformatf("unexpected chunk: kind %0d code %0d closing %b last %b",
                     got.chunk_kind, got.keyword_code, got.closing_tag, got.last_of_run));
      return;
    end
    want = chunk_q.pop_front();
    if (got.chunk_kind != want.chunk_kind || got.keyword_code != want.keyword_code ||
        got.closing_tag != want.closing_tag || got.last_of_run != want.last_of_run)
      flag($sformatf({"chunk mismatch: expected kind %0d code %0d closing %b last %b,",
                      " got kind %0d code %0d closing %b last %b"},
                     want.chunk_kind, want.keyword_code, want.closing_tag, want.last_of_run,
                     got.chunk_kind, got.keyword_code, got.closing_tag, got.last_of_run));
    case (want.chunk_kind)
      ChunkText: n_text++;
      ChunkEnd:  n_end++;
      default:   n_tag++;
    endcase
    if (want.chunk_kind == ChunkRec) kw_seen[want.keyword_code] = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q.delete();
      chunk_st = StIdle;
      open_name();
      fails   = 0;
      n_text  = 0;
      n_tag   = 0;
      n_end   = 0;
      kw_seen = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_request(in_ch.data_byte, in_ch.end_of_input);
      if (out_ch.valid && out_ch.ready) check_chunk();
    end
    fail_count_o <= fails;
    pending_o    <= chunk_q.size();
    text_cnt_o   <= n_text;
    tag_cnt_o    <= n_tag;
    end_cnt_o    <= n_end;
    kw_seen_o    <= kw_seen;
  end

endmodule

@@ test/testbench.sv @@
// Testbench top: byte stimulus, output stalls, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;
  import mtkc_pkg::*;

  localparam int unsigned TagWindow   = 28;
  localparam int unsigned RandomBytes = 1500;
  localparam int unsigned CycleLimit  = 400000;
  // Results pass through the output queue after acceptance; this covers that and slack.
  localparam int unsigned DrainCycles = 20;

  logic clk_i;
  logic rst_ni;

  mtkc_in_if  in_ch ();
  mtkc_out_if out_ch ();

  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        text_cnt, tag_cnt, end_cnt;
  logic [KwTable-1:0] kw_seen;

  int unsigned sent;        // accepted byte requests
  int unsigned cycles;
  bit          calm;        // no idling on either side while set
  bit          drained;     // the one drain-to-empty pause has happened

  markup_tag_keyword_classifier #(
    .TAG_WINDOW    (TagWindow),
    .KEYWORD_COUNT (KwTable)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  mtkc_chunk_checker #(
    .TAG_WINDOW (TagWindow)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .text_cnt_o   (text_cnt),
    .tag_cnt_o    (tag_cnt),
    .end_cnt_o    (end_cnt),
    .kw_seen_o    (kw_seen)
  );

  // 12 ns clock.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d chunks still outstanding", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Output side: stalls about 38% of cycles, except during the calm stretch.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
    end
  end

  // One byte request. Valid stays high on return; the next call either
  // reloads it or drops it for a gap, so no byte is taken twice.
  task automatic send_req(input logic [7:0] b, input logic eoi);
    while (!calm && $urandom_range(99) < 38) begin
      in_ch.valid        <= 1'b0;
      in_ch.data_byte    <= 8'($urandom);
      in_ch.end_of_input <= 1'($urandom);
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.end_of_input <= eoi;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_req(b, 1'b0);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_blank();
    return $urandom_range(1) ? ChSpace : ChTab;
  endfunction

  function automatic logic [7:0] pick_alnum();
    int unsigned k;
    k = $urandom_range(61);
    if (k < 10) return 8'("0" + k);
    if (k < 36) return 8'("A" + k - 10);
    return 8'("a" + k - 36);
  endfunction

  // Attribute filler: mostly printable, sometimes any nonzero byte; never '>'.
  function automatic logic [7:0] pick_attr();
    logic [7:0] c;
    c = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(32, 126));
    return (c == ChGt) ? ChSpace : c;
  endfunction

  // Well-formed tag: optional leading blanks, optional '/', a keyword in
  // mixed case (or a random name), then an optional tail. With cut set the '>'
  // is left off so the end marker lands on an open tag.
  task automatic send_tag(input bit cut);
    int unsigned idx, n;
    logic [7:0]  c;
    send_byte(ChLt);
    // Occasionally many blanks, sometimes enough to run the name window out early.
    if ($urandom_range(9) == 0)      n = $urandom_range(20, 30);
    else if ($urandom_range(2) == 0) n = $urandom_range(1, 2);
    else                             n = 0;
    repeat (n) send_byte(pick_blank());
    if ($urandom_range(99) < 35) begin
      send_byte(ChSlash);
      repeat ($urandom_range(2)) send_byte(pick_blank());
    end
    if ($urandom_range(99) < 80) begin
      idx = $urandom_range(KwTable - 1);
      for (int k = 0; k < KwLen[idx]; k++) begin
        c = KwStr[idx][8*(KwLen[idx]-1-k) +: 8];
        if (c >= "A" && c <= "Z" && $urandom_range(1)) c = c + CaseFold;
        send_byte(c);
      end
    end else begin
      repeat ($urandom_range(1, 5)) send_byte(pick_alnum());
    end
    case ($urandom_range(9))
      0, 1, 2: ;                                     // closes right after the name
      3, 4: begin                                    // attributes
        send_byte(ChSpace);
        repeat ($urandom_range(6)) send_byte(pick_attr());
      end
      5: repeat ($urandom_range(1, 3)) send_byte(pick_alnum());  // longer name
      6: repeat ($urandom_range(20, 40)) send_byte(pick_attr()); // can run past the window
      7: begin                                       // zero byte closes the window
        send_byte(ChNul);
        repeat ($urandom_range(3)) send_byte(pick_attr());
      end
      default: send_byte(8'($urandom_range(33, 47)));            // punctuation
    endcase
    if (!cut) send_byte(ChGt);
  endtask

  task automatic send_text();
    logic [7:0] c;
    if ($urandom_range(7) == 0) send_byte(ChNl);   // run opening with a newline
    repeat ($urandom_range(1, 12)) begin
      c = 8'($urandom_range(32, 126));
      send_byte((c == ChLt) ? ChSpace : c);
    end
    if ($urandom_range(99) < 60) send_byte(ChNl);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned goal;
    sent    = 0;
    cycles  = 0;
    calm    = 1'b0;
    drained = 1'b0;
    rst_ni             <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.data_byte    <= 8'h00;
    in_ch.end_of_input <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: end with nothing open, a run opening with a newline, text
    // cut by '<', a closing tag with blanks around the slash, a zero byte
    // inside a tag, an unknown tag, and a tag still open at the end.
    send_req(8'hFF, 1'b1);
    send_str("\n\n");
    send_byte(8'hFF);
    send_str("< / h1>");
    send_str("<b");
    send_byte(ChNul);
    send_str("z>");
    send_str("<z>");
    send_str("<p");
    send_req(8'h00, 1'b1);

    // Random documents; the stream restarts after each end marker.
    goal = sent + RandomBytes;
    while (sent < goal) begin
      calm = (sent >= 600 && sent < 800);
      if (!drained && sent >= 1000) begin
        // Hold the sender until every pending chunk is out.
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
        drained = 1'b1;
      end
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: send_tag(1'b0);
          11, 12, 13, 14, 15, 16:           send_text();
          default:                          send_noise();
        endcase
      end
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(4) == 0) send_tag(1'b1);
        send_req(8'($urandom), 1'b1);
      end
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d byte requests; checked %0d text runs, %0d tags, %0d end markers",
             sent, text_cnt, tag_cnt, end_cnt);
    $display("Recognised %0d of %0d keywords; %0d mismatches",
             $countones(kw_seen), KwTable, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/mtkc_pkg.sv
sv/mtkc_if.sv
sv/markup_tag_keyword_classifier.sv
test/mtkc_chunk_checker.sv
test/testbench.sv
